### rtl/core/sha256_hmac_stream_signer_top_macros.svh
// assertion macros for the signer
`ifndef SHA256_HMAC_STREAM_SIGNER_TOP_MACROS_SVH
`define SHA256_HMAC_STREAM_SIGNER_TOP_MACROS_SVH

// implication checked every cycle out of reset
`define SHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/shs_pkg.sv
package shs_pkg;

    localparam logic [7:0] PAD_INNER = 8'h36;
    localparam logic [7:0] PAD_OUTER = 8'h5c;
    localparam logic [7:0] PAD_MARK  = 8'h80;
    // 96 byte inner/outer message is 768 bits
    localparam logic [7:0] HMAC_LEN_HI = 8'h03;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic       byte_en;
        logic [7:0] data;
        logic       start;
        logic       init;
    } t_core_cmd;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

### rtl/core/shs_core.sv
module shs_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shs_pkg::t_core_cmd i_cmd,
    output logic              o_done,
    output logic [255:0]      o_cv
);

    logic [511:0] r_w;
    logic [255:0] r_cv;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [5:0]   r_rnd;
    logic         r_run, r_add, r_done;

    logic [31:0] w0, w1, w9, w14, w_new, t1, t2;

    assign w0  = r_w[511:480];
    assign w1  = r_w[479:448];
    assign w9  = r_w[223:192];
    assign w14 = r_w[63:32];
    // window holds W[t..t+15], append W[t+16]
    assign w_new = shs_pkg::small_s1(w14) + w9 + shs_pkg::small_s0(w1) + w0;
    assign t1 = r_h + shs_pkg::big_s1(r_e) + ((r_e & r_f) ^ (~r_e & r_g))
              + shs_pkg::round_k(r_rnd) + w0;
    assign t2 = shs_pkg::big_s0(r_a) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_add  <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
            r_cv   <= shs_pkg::INIT_HASH;
        end else begin
            r_done <= r_add;
            r_add  <= 1'b0;
            if (i_cmd.init) begin
                r_cv <= shs_pkg::INIT_HASH;
            end
            if (i_cmd.start) begin
                r_run <= 1'b1;
                r_rnd <= '0;
                {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= r_cv;
            end else if (r_run) begin
                r_a <= t1 + t2;
                r_b <= r_a;
                r_c <= r_b;
                r_d <= r_c;
                r_e <= r_d + t1;
                r_f <= r_e;
                r_g <= r_f;
                r_h <= r_g;
                r_w <= {r_w[479:0], w_new};
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_run <= 1'b0;
                    r_add <= 1'b1;
                end
            end else if (r_add) begin
                r_cv <= {r_cv[255:224] + r_a, r_cv[223:192] + r_b,
                         r_cv[191:160] + r_c, r_cv[159:128] + r_d,
                         r_cv[127:96] + r_e,  r_cv[95:64] + r_f,
                         r_cv[63:32] + r_g,   r_cv[31:0] + r_h};
            end
            if (i_cmd.byte_en) begin
                r_w <= {r_w[503:0], i_cmd.data};
            end
        end
    end

    assign o_done = r_done;
    assign o_cv   = r_cv;

endmodule

### rtl/core/sha256_hmac_stream_signer_top.sv
// input: one byte per cycle, stalled while each full 64-byte block is compressed
// finishing: padding bytes fed at one per cycle, then one compression per block,
// one or two blocks for a plain digest, four more for the hmac
// throughput set by the single round unit, which stalls input during each compression
// reset: synchronous active low, hash state to initial values, mode 1, key 0
module sha256_hmac_stream_signer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_part,
    output logic [1:0]  o_part_index,
    output logic        o_last_part,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FEED  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_COMP  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_PAD  = 2'd1;
    localparam logic [1:0] PH_KEY  = 2'd2;
    localparam logic [1:0] PH_DIG  = 2'd3;

    localparam logic [2:0] R_MODE = 3'd0;
    localparam logic [2:0] R_KEY0 = 3'd1;
    localparam logic [2:0] R_KEY1 = 3'd2;
    localparam logic [2:0] R_KEY2 = 3'd3;
    localparam logic [2:0] R_KEY3 = 3'd4;

    logic [2:0]   r_state;
    logic [1:0]   r_phase;
    logic [5:0]   r_pos;
    logic         r_first, r_two, r_outer, r_pend, r_mode;
    logic [63:0]  r_bits, r_len;
    logic [255:0] r_key, r_dig;
    logic [1:0]   r_idx;

    shs_pkg::t_core_cmd cmd;
    logic         core_done;
    logic [255:0] core_cv;
    logic         in_acc, out_acc;
    logic [5:0]   pos_new;
    logic [7:0]   feed_byte, kb;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign pos_new = i_has_byte ? r_pos + 6'd1 : r_pos;

    always_comb begin
        kb = (r_pos[5] == 1'b0) ? r_key[{~r_pos[4:0], 3'b000} +: 8] : 8'h00;
        case (r_phase)
            PH_PAD: begin
                if (r_first) begin
                    feed_byte = shs_pkg::PAD_MARK;
                end else if (!r_two && r_pos >= 6'd56) begin
                    feed_byte = r_len[{~r_pos[2:0], 3'b000} +: 8];
                end else begin
                    feed_byte = 8'h00;
                end
            end
            PH_KEY: begin
                feed_byte = kb ^ (r_outer ? shs_pkg::PAD_OUTER : shs_pkg::PAD_INNER);
            end
            PH_DIG: begin
                if (r_pos[5] == 1'b0) begin
                    feed_byte = r_dig[{~r_pos[4:0], 3'b000} +: 8];
                end else if (r_pos == 6'd32) begin
                    feed_byte = shs_pkg::PAD_MARK;
                end else if (r_pos == 6'd62) begin
                    feed_byte = shs_pkg::HMAC_LEN_HI;
                end else begin
                    feed_byte = 8'h00;
                end
            end
            default: feed_byte = 8'h00;
        endcase
    end

    always_comb begin
        cmd.byte_en = 1'b0;
        cmd.data    = feed_byte;
        cmd.start   = (r_state == S_START);
        cmd.init    = 1'b0;
        if (r_state == S_IDLE) begin
            cmd.byte_en = in_acc && i_has_byte;
            cmd.data    = i_data_byte;
        end else if (r_state == S_FEED) begin
            cmd.byte_en = 1'b1;
        end
        if (r_state == S_COMP && core_done) begin
            if (r_phase == PH_PAD && !r_two && r_mode) begin
                cmd.init = 1'b1;
            end else if (r_phase == PH_DIG && !r_outer) begin
                cmd.init = 1'b1;
            end
        end
        if (out_acc && r_idx == 2'd3) begin
            cmd.init = 1'b1;
        end
    end

    shs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_done  (core_done),
        .o_cv    (core_cv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DATA;
            r_pos   <= '0;
            r_first <= 1'b0;
            r_two   <= 1'b0;
            r_outer <= 1'b0;
            r_pend  <= 1'b0;
            r_bits  <= '0;
            r_idx   <= '0;
            r_mode  <= 1'b1;
            r_key   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    R_MODE:  r_mode <= i_cfg_data[0];
                    R_KEY0:  r_key[255:192] <= i_cfg_data;
                    R_KEY1:  r_key[191:128] <= i_cfg_data;
                    R_KEY2:  r_key[127:64]  <= i_cfg_data;
                    R_KEY3:  r_key[63:0]    <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pos <= pos_new;
                        if (i_has_byte && r_pos == 6'd63) begin
                            r_bits  <= r_bits + 64'd512;
                            r_pend  <= i_last_byte;
                            r_phase <= PH_DATA;
                            r_state <= S_START;
                        end else if (i_last_byte) begin
                            r_len   <= r_bits + {55'd0, pos_new, 3'b000};
                            r_two   <= (pos_new >= 6'd56);
                            r_first <= 1'b1;
                            r_phase <= PH_PAD;
                            r_state <= S_FEED;
                        end
                    end
                end
                S_FEED: begin
                    r_first <= 1'b0;
                    r_pos   <= r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_COMP;
                end
                S_COMP: begin
                    if (core_done) begin
                        r_state <= S_FEED;
                        case (r_phase)
                            PH_DATA: begin
                                if (r_pend) begin
                                    r_len   <= r_bits;
                                    r_two   <= 1'b0;
                                    r_first <= 1'b1;
                                    r_phase <= PH_PAD;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            PH_PAD: begin
                                if (r_two) begin
                                    r_two <= 1'b0;
                                end else begin
                                    r_dig <= core_cv;
                                    if (r_mode) begin
                                        r_outer <= 1'b0;
                                        r_phase <= PH_KEY;
                                    end else begin
                                        r_idx   <= '0;
                                        r_state <= S_OUT;
                                    end
                                end
                            end
                            PH_KEY: begin
                                r_phase <= PH_DIG;
                            end
                            PH_DIG: begin
                                r_dig <= core_cv;
                                if (!r_outer) begin
                                    r_outer <= 1'b1;
                                    r_phase <= PH_KEY;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= S_OUT;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            r_pos   <= '0;
                            r_bits  <= '0;
                            r_pend  <= 1'b0;
                            r_phase <= PH_DATA;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_part = r_dig[{~r_idx, 6'b000000} +: 64];
    assign o_part_index  = r_idx;
    assign o_last_part   = (r_idx == 2'd3);

`include "sha256_hmac_stream_signer_top_macros.svh"

    `SHS_ASSERT_IMP(a_done_in_comp, i_clk, i_rst_n, core_done, r_state == S_COMP,
        "core done outside compression wait")
    `SHS_ASSERT_NEXT(a_restart, i_clk, i_rst_n, out_acc && o_last_part,
        r_pos == 6'd0 && r_bits == 64'd0 && r_state == S_IDLE,
        "hash state not restarted after last beat")
    `SHS_ASSERT_IMP(a_feed_byte_count, i_clk, i_rst_n, r_state == S_START,
        $past(r_pos) == 6'd63, "compression started on partial block")

endmodule
